// File: src/sfc_pkg.sv
`timescale 1ns / 1ps
package sfc_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int NUM_REGS      = 8;
  localparam int NUM_PLANES    = 6;
  localparam int REG_W         = 64;
  localparam int IDX_W         = $clog2(NUM_REGS);

  localparam int C_W   = 32;              // center coordinate
  localparam int R_W   = 31;              // radius
  localparam int CP_W  = C_W + 1;         // plane component
  localparam int P_W   = CP_W + C_W;      // component times center
  localparam int NSQ_W = 2 * CP_W;        // squared component
  localparam int S_W   = 68;              // signed plane sum, also |n|^2
  localparam int H_W   = S_W / 2;         // half of a split 68-bit value
  localparam int RR_W  = 2 * R_W;         // radius squared
  localparam int RH_W  = RR_W / 2;        // half of radius squared
  localparam int SQ_W  = 2 * S_W;         // Q(4F) products

  typedef logic signed [CP_W-1:0] comp_t;
  typedef logic signed [C_W-1:0]  coord_t;
  typedef comp_t plane_t [4];

endpackage

// File: src/sfc_plane.sv
`timescale 1ns / 1ps
module sfc_plane (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  sfc_pkg::plane_t            comp_i,
  input  sfc_pkg::coord_t            cx_i,
  input  sfc_pkg::coord_t            cy_i,
  input  sfc_pkg::coord_t            cz_i,
  input  logic [sfc_pkg::RR_W-1:0]   rr_i,
  output logic                       cull_o
);

  localparam int PW = sfc_pkg::P_W;
  localparam int SW = sfc_pkg::S_W;
  localparam int HW = sfc_pkg::H_W;
  localparam int RH = sfc_pkg::RH_W;
  localparam int QW = sfc_pkg::SQ_W;

  sfc_pkg::coord_t          c [3];
  logic signed [PW-1:0]     prod_q [3];
  logic [sfc_pkg::NSQ_W-1:0] nsq_q [3];
  sfc_pkg::comp_t           w_q;
  logic                     zero_q, zero_c_q;
  logic signed [SW-1:0]     s_q;
  logic [SW-1:0]            len_q, len_d_q, mag_q;
  logic                     keep_d_q, keep_e_q, keep_f_q;
  logic [2*HW-1:0]          hh_q, hl_q, ll_q;
  logic [HW+RH-1:0]         lhh_q, lhl_q, llh_q, lll_q;
  logic [QW-1:0]            sq_q, lr_q;
  logic                     cull_q;

  assign c[0] = cx_i;
  assign c[1] = cy_i;
  assign c[2] = cz_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Products of the normal with the center, and squared normal parts.
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= PW'(comp_i[k]) * PW'(c[k]);
        nsq_q[k]  <= sfc_pkg::NSQ_W'(sfc_pkg::NSQ_W'(comp_i[k]) * sfc_pkg::NSQ_W'(comp_i[k]));
      end
      w_q    <= comp_i[3];
      zero_q <= (comp_i[0] == '0) && (comp_i[1] == '0) && (comp_i[2] == '0);

      s_q <= SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2])
           + (SW'(w_q) <<< sfc_pkg::FRACTION_BITS);
      len_q    <= SW'(nsq_q[0]) + SW'(nsq_q[1]) + SW'(nsq_q[2]);
      zero_c_q <= zero_q;

      // Only a plane with a nonzero normal and a negative sum can cull.
      keep_d_q <= !zero_c_q && s_q[SW-1];
      mag_q    <= s_q[SW-1] ? SW'(-s_q) : SW'(s_q);
      len_d_q  <= len_q;

      hh_q  <= (2*HW)'(mag_q[SW-1:HW]) * (2*HW)'(mag_q[SW-1:HW]);
      hl_q  <= (2*HW)'(mag_q[SW-1:HW]) * (2*HW)'(mag_q[HW-1:0]);
      ll_q  <= (2*HW)'(mag_q[HW-1:0]) * (2*HW)'(mag_q[HW-1:0]);
      lhh_q <= (HW+RH)'(len_d_q[SW-1:HW]) * (HW+RH)'(rr_i[2*RH-1:RH]);
      lhl_q <= (HW+RH)'(len_d_q[SW-1:HW]) * (HW+RH)'(rr_i[RH-1:0]);
      llh_q <= (HW+RH)'(len_d_q[HW-1:0]) * (HW+RH)'(rr_i[2*RH-1:RH]);
      lll_q <= (HW+RH)'(len_d_q[HW-1:0]) * (HW+RH)'(rr_i[RH-1:0]);
      keep_e_q <= keep_d_q;

      sq_q <= (QW'(hh_q) << (2*HW)) + (QW'(hl_q) << (HW+1)) + QW'(ll_q);
      lr_q <= (QW'(lhh_q) << (HW+RH)) + (QW'(lhl_q) << HW)
            + (QW'(llh_q) << RH) + QW'(lll_q);
      keep_f_q <= keep_e_q;

      // A tangent sphere is not culled.
      cull_q <= keep_f_q && (sq_q > lr_q);
    end
  end

  assign cull_o = cull_q;

endmodule

// File: src/sphere_frustum_cull.sv
`timescale 1ns / 1ps
// Sphere against view frustum test. Each accepted request carries a sphere
// center and radius; the result is 1 when no frustum plane rejects the
// sphere. The six planes are formed from the view-projection matrix held in
// eight 64-bit registers, written through the cfg port; the user must write
// them only while the block is idle, which the block itself does not enforce.
// A new sphere is taken every cycle unless the output stalls; the result
// passes eight register stages of input register, products, plane sums,
// magnitude, split squares, partial-product sums, compare and output
// register. Backpressure on the output stalls the whole pipeline.
module sphere_frustum_cull (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sfc_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [sfc_pkg::REG_W-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // center_x [31:0], center_y [63:32], center_z [95:64],
  // sphere_radius [126:96], zero [127]
  input  logic [127:0]                  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // inside_res [0], zero [7:1]
  output logic [7:0]                    m_axis_tdata
);

  localparam int NP     = sfc_pkg::NUM_PLANES;
  localparam int STAGES = 8;

  logic [sfc_pkg::REG_W-1:0] cfg_q [sfc_pkg::NUM_REGS];
  sfc_pkg::plane_t           comp [NP];
  logic [STAGES-1:0]         vld_q;
  logic                      en;
  sfc_pkg::coord_t           cx_q, cy_q, cz_q;
  logic [sfc_pkg::R_W-1:0]   r_q;
  logic [sfc_pkg::RR_W-1:0]  rr_b_q, rr_c_q, rr_d_q;
  logic [NP-1:0]             cull;
  logic                      inside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sfc_pkg::NUM_REGS; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Plane p uses row p/2, added for even p and subtracted for odd p.
  always_comb begin
    logic signed [31:0] a;
    logic signed [31:0] b;
    for (int p = 0; p < NP; p++) begin
      for (int k = 0; k < 4; k++) begin
        a = cfg_q[k*2+1][63:32];
        b = ((p / 2) % 2 == 1) ? cfg_q[k*2 + (p/2)/2][63:32]
                               : cfg_q[k*2 + (p/2)/2][31:0];
        comp[p][k] = (p % 2 == 1) ? sfc_pkg::CP_W'(a) - sfc_pkg::CP_W'(b)
                                  : sfc_pkg::CP_W'(a) + sfc_pkg::CP_W'(b);
      end
    end
  end

  assign en            = !vld_q[STAGES-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[STAGES-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q   <= s_axis_tdata[31:0];
      cy_q   <= s_axis_tdata[63:32];
      cz_q   <= s_axis_tdata[95:64];
      r_q    <= s_axis_tdata[126:96];
      rr_b_q <= sfc_pkg::RR_W'(r_q) * sfc_pkg::RR_W'(r_q);
      rr_c_q <= rr_b_q;
      rr_d_q <= rr_c_q;
      inside_q <= ~|cull;
    end
  end

  for (genvar p = 0; p < NP; p++) begin : g_plane
    sfc_plane u_plane (
      .clk_i  (clk_i),
      .en_i   (en),
      .comp_i (comp[p]),
      .cx_i   (cx_q),
      .cy_i   (cy_q),
      .cz_i   (cz_q),
      .rr_i   (rr_d_q),
      .cull_o (cull[p])
    );
  end

  assign m_axis_tvalid = vld_q[STAGES-1];
  assign m_axis_tdata  = {7'd0, inside_q};

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
class cull_scoreboard;
  logic [63:0] matrix_regs [8];
  bit inside_q [$];
  int unsigned errors;

  function new();
    foreach (matrix_regs[i]) matrix_regs[i] = '0;
    errors = 0;
  endfunction

  function void write_reg(int idx, logic [63:0] value);
    matrix_regs[idx] = value;
  endfunction

  function logic signed [32:0] entry(int col, int row);
    logic [63:0] r;
    logic [31:0] half;
    r = matrix_regs[col * 2 + row / 2];
    half = (row % 2) ? r[63:32] : r[31:0];
    return {half[31], half};
  endfunction

  function bit predict_inside(logic [127:0] d);
    logic signed [255:0] center [3];
    logic signed [255:0] comp [4];
    logic signed [255:0] s, len2, rr;
    logic signed [32:0] a, b;
    int j;
    for (int k = 0; k < 3; k++) center[k] = $signed(d[32*k +: 32]);
    rr = $signed({1'b0, d[126:96]});
    rr = rr * rr;
    for (int p = 0; p < 6; p++) begin
      j = p / 2;
      for (int k = 0; k < 4; k++) begin
        a = entry(k, 3);
        b = entry(k, j);
        comp[k] = (p % 2) ? a - b : a + b;
      end
      // A plane with no normal is skipped.
      if (comp[0] == 0 && comp[1] == 0 && comp[2] == 0) continue;
      s = comp[0] * center[0] + comp[1] * center[1] + comp[2] * center[2]
          + (comp[3] <<< sfc_pkg::FRACTION_BITS);
      if (s >= 0) continue;
      len2 = comp[0] * comp[0] + comp[1] * comp[1] + comp[2] * comp[2];
      if (s * s > len2 * rr) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void note_sphere(logic [127:0] d);
    inside_q.push_back(predict_inside(d));
  endfunction

  function void check_result(logic [7:0] d);
    bit expected;
    if (inside_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %0d", $time, d[0]);
      errors++;
      return;
    end
    expected = inside_q.pop_front();
    if (d[0] !== expected || d[7:1] !== 7'd0) begin
      $display("%0t: inside_res mismatch, expected %0d, actual %0h", $time,
               expected, d);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [sfc_pkg::IDX_W-1:0] cfg_idx_i = '0;
  logic [sfc_pkg::REG_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;

  cull_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int unsigned stuck_cycles = 0;

  always #4 clk_i = ~clk_i;

  sphere_frustum_cull DUT (.*);

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) sb.note_sphere(s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= 3000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off, none near the end.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (n = 0; n < 300; n++) @(posedge clk_i);
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
    end
  end

  task automatic send_sphere(logic [127:0] d);
    s_axis_tdata <= d;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic write_matrix(logic [63:0] value [8]);
    // Stop offering requests so that the pipeline can drain.
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (sb.inside_q.size() == 0);
    repeat (10) @(posedge clk_i);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= sfc_pkg::IDX_W'(i);
      cfg_data_i <= value[i];
      @(posedge clk_i);
      sb.write_reg(i, value[i]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [127:0] sphere(logic [31:0] x, logic [31:0] y,
                                          logic [31:0] z, logic [30:0] r);
    return {1'b0, r, z, y, x};
  endfunction

  function automatic logic [31:0] rand_coord();
    return $signed($urandom) >>> $urandom_range(0, 24);
  endfunction

  function automatic logic [127:0] rand_sphere();
    logic [31:0] rv;
    rv = $urandom >> (1 + $urandom_range(0, 24));
    return sphere(rand_coord(), rand_coord(), rand_coord(), rv[30:0]);
  endfunction

  task automatic random_spheres(int count);
    for (int i = 0; i < count; i++) send_sphere(rand_sphere());
  endtask

  initial begin
    logic [63:0] m [8];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset matrix: every plane has no normal, so every sphere is inside.
    send_sphere(sphere(32'h0, 32'h0, 32'h0, 31'h0));
    send_sphere(sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF));
    random_spheres(40);

    // Unit diagonal: planes at x, y, z = -1 and +1.
    foreach (m[i]) m[i] = '0;
    m[0] = 64'h0000_0000_0001_0000;
    m[3] = 64'h0000_0000_0000_0000;
    m[2] = 64'h0001_0000_0000_0000;
    m[5] = 64'h0000_0000_0001_0000;
    m[7] = 64'h0001_0000_0000_0000;
    write_matrix(m);
    send_sphere(sphere(32'h0, 32'h0, 32'h0, 31'h0));
    // Tangent to the left plane: not culled.
    send_sphere(sphere(32'hFFFE_0000, 32'h0, 32'h0, 31'h0001_0000));
    send_sphere(sphere(32'hFFFE_0000, 32'h0, 32'h0, 31'h0000_FFFF));
    send_sphere(sphere(32'h0002_0000, 32'h0, 32'h0, 31'h0000_FFFF));
    send_sphere(sphere(32'h0, 32'hFFFD_0000, 32'h0, 31'h0001_0000));
    send_sphere(sphere(32'h0, 32'h0003_0000, 32'h0, 31'h0002_0000));
    send_sphere(sphere(32'h0, 32'h0, 32'hFFFD_0000, 31'h0));
    send_sphere(sphere(32'h0, 32'h0, 32'h0003_0000, 31'h0000_0001));
    send_sphere(sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0));
    send_sphere(sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0));
    send_sphere(sphere(32'h8000_0000, 32'h0, 32'h0, 31'h7FFF_FFFF));
    send_sphere(sphere(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
    random_spheres(180);

    // Let the input fill up while results are held back.
    hold_req = 1'b1;
    random_spheres(150);

    // All entries at -1 LSB.
    foreach (m[i]) m[i] = '1;
    write_matrix(m);
    random_spheres(120);

    // Entries at the signed extremes.
    foreach (m[i]) m[i] = (i % 2) ? 64'h8000_0000_7FFF_FFFF : 64'h7FFF_FFFF_8000_0000;
    write_matrix(m);
    random_spheres(120);

    foreach (m[i]) m[i] = {$urandom, $urandom};
    write_matrix(m);
    random_spheres(150);

    foreach (m[i]) m[i] = {rand_coord(), rand_coord()};
    write_matrix(m);
    random_spheres(200);

    foreach (m[i]) m[i] = {rand_coord(), rand_coord()};
    write_matrix(m);
    quiet = 1'b1;
    random_spheres(180);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (sb.inside_q.size() == 0);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
